[design/tci_pkg.sv]
// shared types, widths and constants of the table cubic interpolator
package tci_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int FRACTION_BITS = 16;

  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int N_W      = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_W    = 11;
  localparam int CMP_W    = (N_W > CFG_W) ? N_W : CFG_W;
  localparam int SRCH_W   = N_W + 1;
  localparam int KEY_W    = 32;
  localparam int DIFF_W   = KEY_W + 1;
  localparam int FRAC_W   = FRACTION_BITS + 1;
  localparam int ACC_W    = 40;
  localparam int PROD_W   = ACC_W + FRAC_W;
  localparam int DCNT_W   = $clog2(FRACTION_BITS + 1);

  localparam logic [FRAC_W-1:0] F_ONE = FRAC_W'(1) << FRACTION_BITS;
  localparam logic signed [PROD_W-1:0] P_HALF = PROD_W'(1) << (FRACTION_BITS - 1);
  localparam logic signed [ACC_W-1:0] V_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] V_MIN = -(ACC_W'(64'sd2147483648));

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [9:0]        entry_index;
    logic signed [31:0] key_value;
    logic signed [31:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIFF_W-1:0] num;
    logic [DIFF_W-1:0] den;
  } div_req_t;

endpackage

[design/tci_div.sv]
// serial restoring divider for the segment fraction, one quotient bit a cycle
module tci_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tci_pkg::div_req_t req,
  output logic              done,
  output logic [tci_pkg::FRAC_W-1:0] quot
);
  import tci_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIFF_W:0]   rem_r, rem_nxt;
  logic [DIFF_W-1:0] den_r, den_nxt;
  logic [FRAC_W-1:0] q_r, q_nxt;
  logic [DIFF_W:0]   rem2;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    rem2     = {rem_r[DIFF_W-1:0], 1'b0};
    if (req.start) begin
      den_nxt = req.den;
      if (req.num >= req.den) begin
        // quotient reaches one, clamp right away
        q_nxt    = F_ONE;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = {1'b0, req.num};
        q_nxt    = '0;
        cnt_nxt  = DCNT_W'(FRACTION_BITS);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (rem2 >= {1'b0, den_r}) begin
        rem_nxt = rem2 - {1'b0, den_r};
        q_nxt   = {q_r[FRAC_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem2;
        q_nxt   = {q_r[FRAC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[design/tci_mul.sv]
// registered signed by fraction multiplier shared by all horner passes
module tci_mul (
  input  logic                              clk,
  input  logic signed [tci_pkg::ACC_W-1:0]  a,
  input  logic [tci_pkg::FRAC_W-1:0]        f,
  output logic signed [tci_pkg::PROD_W-1:0] p
);
  import tci_pkg::*;

  logic signed [PROD_W:0]   prod_full;
  logic signed [PROD_W-1:0] p_r;

  always_comb begin
    prod_full = a * $signed({1'b0, f});
  end

  always_ff @(posedge clk) begin
    p_r <= $signed(prod_full[PROD_W-1:0]);
  end

  assign p = p_r;

endmodule

[design/table_cubic_interpolator.sv]
// top level: table store, search and interpolation sequencer
//
// channel | dir | handshake            | payload
// in_     | in  | in_valid / in_ready  | in_item (cmd, entry_index, key_value, entry_data)
// out_    | out | out_valid / out_ready| out_item (interp_value, saturated)
// cfg_    | in  | cfg_valid / cfg_ready| cfg_wdata (entries_in_use)
//
// a write transaction gives no result
// a query beyond an end key skips the search, the division and the
//   multiplier passes; other queries run a binary search over the single
//   key read port, the serial divider where the fraction needs it, and the
//   passes through the shared multiplier, fewer for a linear query than a cubic one
// in_ready is high only while the sequencer is idle; a result waits in the
//   output register, so a new transaction is taken while it is pending, and
//   the next result holds the sequencer until the pending one has left
// reset is synchronous active low; the tables are not cleared
module table_cubic_interpolator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tci_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tci_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tci_pkg::CFG_W-1:0] cfg_wdata
);
  import tci_pkg::*;

  typedef enum logic [17:0] {
    Q_IDLE  = 18'b000000000000000001,
    Q_K0    = 18'b000000000000000010,
    Q_KN    = 18'b000000000000000100,
    Q_CHK   = 18'b000000000000001000,
    Q_END   = 18'b000000000000010000,
    Q_SRCH  = 18'b000000000000100000,
    Q_CMP   = 18'b000000000001000000,
    Q_RES   = 18'b000000000010000000,
    Q_KI    = 18'b000000000100000000,
    Q_KI1   = 18'b000000001000000000,
    Q_DEN   = 18'b000000010000000000,
    Q_DIV   = 18'b000000100000000000,
    Q_VRD   = 18'b000001000000000000,
    Q_VLAST = 18'b000010000000000000,
    Q_COEF  = 18'b000100000000000000,
    Q_MUL   = 18'b001000000000000000,
    Q_ACC   = 18'b010000000000000000,
    Q_OUT   = 18'b100000000000000000
  } state_t;

  // table storage, one read port each with registered data
  logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic signed [KEY_W-1:0] val_mem [TABLE_DEPTH];
  logic signed [KEY_W-1:0] key_rd_r, val_rd_r;
  logic [IDX_W-1:0]        key_addr, val_addr;

  state_t                   state_r, state_nxt;
  logic [CFG_W-1:0]         cfg_r, cfg_nxt;
  logic signed [KEY_W-1:0]  x_r, x_nxt;
  logic [N_W-1:0]           n_r, n_nxt;
  logic signed [KEY_W-1:0]  k0_r, k0_nxt, kn_r, kn_nxt, ki_r, ki_nxt;
  logic                     rising_r, rising_nxt;
  logic signed [SRCH_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_W-1:0]         i_r, i_nxt;
  logic                     cubic_r, cubic_nxt;
  logic [FRAC_W-1:0]        f_r, f_nxt;
  logic [1:0]               cnt_r, cnt_nxt;
  logic                     pend_r, pend_nxt;
  logic [1:0]               pidx_r, pidx_nxt;
  logic signed [KEY_W-1:0]  y_r [4];
  logic signed [ACC_W-1:0]  t_r, t_nxt;
  logic signed [ACC_W-1:0]  add_r [3];
  logic signed [ACC_W-1:0]  add_nxt [3];
  logic [1:0]               pass_r, pass_nxt, last_r, last_nxt;
  out_item_t                out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic                     in_acc;
  logic [CMP_W-1:0]         cfg_ext;
  logic signed [SRCH_W:0]   mid_sum;
  logic signed [SRCH_W-1:0] mid_s, n_s, nm2_s, seg_s, i_s;
  logic                     ascend, hi_end, lo_end;
  logic signed [DIFF_W-1:0] num_s, den_s;
  logic signed [ACC_W-1:0]  ym, y0, y1, y2, a0;
  logic signed [PROD_W-1:0] rnd_p;
  div_req_t                 div_req;
  logic                     div_done;
  logic [FRAC_W-1:0]        div_quot;
  logic signed [PROD_W-1:0] mul_p;

  assign in_ready  = (state_r == Q_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign cfg_ext   = CMP_W'(cfg_r);

  // search midpoint, never negative since hi exceeds lo by two or more
  assign mid_sum = SRCH_W'(hi_r) + SRCH_W'(lo_r);
  assign mid_s   = SRCH_W'(mid_sum >>> 1);
  assign n_s     = $signed({1'b0, n_r});
  assign nm2_s   = n_s - SRCH_W'(2);
  assign i_s     = $signed({{(SRCH_W-IDX_W){1'b0}}, i_r});

  // end clamp decision, k0 registered and kn arriving from the key port
  assign ascend = k0_r < key_rd_r;
  assign hi_end = ascend ? (x_r > key_rd_r) : (x_r < key_rd_r);
  assign lo_end = ascend ? (x_r < k0_r) : (x_r > k0_r);

  // segment numerator and width, key[i+1] arrives in Q_DEN
  assign num_s = DIFF_W'(x_r) - DIFF_W'(ki_r);
  assign den_s = DIFF_W'(key_rd_r) - DIFF_W'(ki_r);

  assign ym = ACC_W'(y_r[0]);
  assign y0 = ACC_W'(y_r[1]);
  assign y1 = ACC_W'(y_r[2]);
  assign y2 = ACC_W'(y_r[3]);
  assign a0 = y2 - y1 - ym + y0;

  // rounding half up: arithmetic shift of the biased product
  assign rnd_p = (mul_p + P_HALF) >>> FRACTION_BITS;

  always_comb begin
    priority case (1'b1)
      state_r == Q_KN:  key_addr = IDX_W'(n_r - 1'b1);
      state_r == Q_SRCH: key_addr = IDX_W'(mid_s);
      state_r == Q_KI:  key_addr = i_r;
      state_r == Q_KI1: key_addr = i_r + IDX_W'(1);
      default:          key_addr = '0;
    endcase
    if (state_r == Q_CHK && hi_end) begin
      val_addr = IDX_W'(n_r - 1'b1);
    end else if (state_r == Q_VRD) begin
      val_addr = i_r + IDX_W'(cnt_r) - IDX_W'(cubic_r);
    end else begin
      val_addr = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cfg_nxt       = cfg_r;
    x_nxt         = x_r;
    n_nxt         = n_r;
    k0_nxt        = k0_r;
    kn_nxt        = kn_r;
    ki_nxt        = ki_r;
    rising_nxt    = rising_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    cubic_nxt     = cubic_r;
    f_nxt         = f_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    t_nxt         = t_r;
    add_nxt       = add_r;
    pass_nxt      = pass_r;
    last_nxt      = last_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    seg_s         = lo_r;
    div_req       = '0;

    if (cfg_valid && cfg_ready) begin
      cfg_nxt = cfg_wdata;
    end

    unique case (state_r)
      Q_IDLE: begin
        if (in_acc && in_item.cmd == CMD_QUERY) begin
          x_nxt = in_item.key_value;
          // entry count limited to two up to the table depth
          if (cfg_ext < CMP_W'(2)) begin
            n_nxt = N_W'(2);
          end else if (cfg_ext > CMP_W'(TABLE_DEPTH)) begin
            n_nxt = N_W'(TABLE_DEPTH);
          end else begin
            n_nxt = N_W'(cfg_ext);
          end
          state_nxt = Q_K0;
        end
      end
      Q_K0: state_nxt = Q_KN;
      Q_KN: begin
        k0_nxt    = key_rd_r;
        state_nxt = Q_CHK;
      end
      Q_CHK: begin
        kn_nxt     = key_rd_r;
        rising_nxt = key_rd_r >= k0_r;
        lo_nxt     = -SRCH_W'(1);
        hi_nxt     = n_s;
        if (hi_end || lo_end) begin
          state_nxt = Q_END;
        end else begin
          state_nxt = Q_SRCH;
        end
      end
      Q_END: begin
        // end value taken as is, never out of range
        t_nxt     = ACC_W'(val_rd_r);
        state_nxt = Q_OUT;
      end
      Q_SRCH: begin
        if (hi_r - lo_r > SRCH_W'(1)) begin
          state_nxt = Q_CMP;
        end else begin
          state_nxt = Q_RES;
        end
      end
      Q_CMP: begin
        if ((x_r >= key_rd_r) == rising_r) begin
          lo_nxt = mid_s;
        end else begin
          hi_nxt = mid_s;
        end
        state_nxt = Q_SRCH;
      end
      Q_RES: begin
        // exact end keys first, then clamp into the segment range
        if (x_r == k0_r) begin
          seg_s = '0;
        end else if (x_r == kn_r) begin
          seg_s = nm2_s;
        end else begin
          seg_s = lo_r;
        end
        if (seg_s < 0) begin
          seg_s = '0;
        end
        if (seg_s > nm2_s) begin
          seg_s = nm2_s;
        end
        i_nxt     = IDX_W'(seg_s);
        state_nxt = Q_KI;
      end
      Q_KI: begin
        cubic_nxt = (i_r > IDX_W'(1)) && (i_s < nm2_s);
        state_nxt = Q_KI1;
      end
      Q_KI1: begin
        ki_nxt    = key_rd_r;
        state_nxt = Q_DEN;
      end
      Q_DEN: begin
        cnt_nxt = '0;
        if (den_s != 0 && num_s != 0 && ((num_s > 0) == (den_s > 0))) begin
          div_req.start = 1'b1;
          div_req.num   = num_s[DIFF_W-1] ? DIFF_W'(-num_s) : DIFF_W'(num_s);
          div_req.den   = den_s[DIFF_W-1] ? DIFF_W'(-den_s) : DIFF_W'(den_s);
          state_nxt     = Q_DIV;
        end else begin
          f_nxt     = '0;
          state_nxt = Q_VRD;
        end
      end
      Q_DIV: begin
        if (div_done) begin
          f_nxt     = div_quot;
          state_nxt = Q_VRD;
        end
      end
      Q_VRD: begin
        pend_nxt = 1'b1;
        pidx_nxt = cnt_r;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == (cubic_r ? 2'd3 : 2'd1)) begin
          state_nxt = Q_VLAST;
        end
      end
      Q_VLAST: state_nxt = Q_COEF;
      Q_COEF: begin
        pass_nxt = '0;
        if (cubic_r) begin
          t_nxt      = a0;
          add_nxt[0] = ym - y0 - a0;
          add_nxt[1] = y1 - ym;
          add_nxt[2] = y0;
          last_nxt   = 2'd2;
        end else begin
          // linear blend as y_r[0] + R(f * (y_r[1] - y_r[0]))
          t_nxt      = ACC_W'(y_r[1]) - ACC_W'(y_r[0]);
          add_nxt[0] = ACC_W'(y_r[0]);
          last_nxt   = 2'd0;
        end
        state_nxt = Q_MUL;
      end
      Q_MUL: state_nxt = Q_ACC;
      Q_ACC: begin
        t_nxt      = ACC_W'(rnd_p) + add_r[0];
        add_nxt[0] = add_r[1];
        add_nxt[1] = add_r[2];
        pass_nxt   = pass_r + 1'b1;
        if (pass_r == last_r) begin
          state_nxt = Q_OUT;
        end else begin
          state_nxt = Q_MUL;
        end
      end
      Q_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (t_r > V_MAX) begin
            out_nxt.interp_value = 32'sh7fffffff;
            out_nxt.saturated    = 1'b1;
          end else if (t_r < V_MIN) begin
            out_nxt.interp_value = 32'sh80000000;
            out_nxt.saturated    = 1'b1;
          end else begin
            out_nxt.interp_value = $signed(t_r[31:0]);
            out_nxt.saturated    = 1'b0;
          end
          state_nxt = Q_IDLE;
        end
      end
      default: state_nxt = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= Q_IDLE;
      cfg_r       <= CFG_W'(2);
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
    x_r      <= x_nxt;
    n_r      <= n_nxt;
    k0_r     <= k0_nxt;
    kn_r     <= kn_nxt;
    ki_r     <= ki_nxt;
    rising_r <= rising_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    i_r      <= i_nxt;
    cubic_r  <= cubic_nxt;
    f_r      <= f_nxt;
    cnt_r    <= cnt_nxt;
    pidx_r   <= pidx_nxt;
    t_r      <= t_nxt;
    add_r    <= add_nxt;
    pass_r   <= pass_nxt;
    last_r   <= last_nxt;
    out_r    <= out_nxt;
    // value read issued last cycle lands in its slot
    if (pend_r) begin
      y_r[pidx_r] <= val_rd_r;
    end
  end

  // table write on a write transaction, positions past the depth dropped
  always_ff @(posedge clk) begin
    if (in_acc && in_item.cmd == CMD_WRITE &&
        32'(in_item.entry_index) < 32'(TABLE_DEPTH)) begin
      key_mem[IDX_W'(in_item.entry_index)] <= in_item.key_value;
      val_mem[IDX_W'(in_item.entry_index)] <= in_item.entry_data;
    end
    key_rd_r <= key_mem[key_addr];
    val_rd_r <= val_mem[val_addr];
  end

  tci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  tci_mul u_mul (
    .clk (clk),
    .a   (t_r),
    .f   (f_r),
    .p   (mul_p)
  );

  // the search only probes while the bracket is still open
  a_srch_open: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == Q_CMP |-> (hi_r - lo_r) > SRCH_W'(1))
    else $error("search probe with closed bracket");

  // a divider result only arrives while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == Q_DIV)
    else $error("divider done outside wait state");

  // fraction never exceeds one when multiplied
  a_frac_max: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == Q_MUL |-> f_r <= F_ONE)
    else $error("fraction above one");

  // a new result is only loaded once the previous one left
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_r))
    else $error("pending result overwritten");

endmodule

[verif/tb_table_cubic_interpolator.sv]
// testbench of the table cubic interpolator: directed and random writes and queries
module tb_table_cubic_interpolator;
  import tci_pkg::*;

  localparam int TIMEOUT_CYCLES = 3000000;
  localparam int DRAIN_CYCLES   = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  table_cubic_interpolator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_wdata(cfg_wdata)
  );

  // predictor state: its own copy of the tables and the entry count
  logic signed [31:0] key_mem [TABLE_DEPTH];
  logic signed [31:0] val_mem [TABLE_DEPTH];
  logic [CFG_W-1:0] n_cfg = CFG_W'(2);
  int n_written = 0;

  out_item_t expected_q[$];
  int mismatches = 0;
  longint cycle_count = 0;
  bit timed_out = 1'b0;

  // divide by 2^FRACTION_BITS, half rounded toward plus infinity
  function automatic longint round_frac(longint s);
    longint t;
    t = s + (64'sd1 <<< (FRACTION_BITS - 1));
    return t >>> FRACTION_BITS;
  endfunction

  function automatic int clamp_count();
    int n;
    n = n_cfg;
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  function automatic out_item_t interpolate(logic signed [31:0] key);
    out_item_t r;
    longint x, k0, kn, num, den, f, one, res, ym, y0, y1, y2, a0, a1, a2;
    longint unsigned an, ad, q;
    int n, lo, hi, mid, seg;
    bit rising;
    x = key;
    one = 64'sd1 <<< FRACTION_BITS;
    n = clamp_count();
    k0 = key_mem[0];
    kn = key_mem[n-1];
    r.saturated = 1'b0;
    // beyond either end key: the end value, unflagged
    if (k0 < kn ? x > kn : x < kn) begin
      r.interp_value = val_mem[n-1];
      return r;
    end
    if (k0 < kn ? x < k0 : x > k0) begin
      r.interp_value = val_mem[0];
      return r;
    end
    rising = kn >= k0;
    lo = -1;
    hi = n;
    while (hi - lo > 1) begin
      mid = (hi + lo) / 2;
      if ((x >= longint'(key_mem[mid])) == rising) lo = mid;
      else hi = mid;
    end
    seg = lo;
    if (x == k0) seg = 0;
    else if (x == kn) seg = n - 2;
    if (seg < 0) seg = 0;
    if (seg > n - 2) seg = n - 2;
    num = x - longint'(key_mem[seg]);
    den = longint'(key_mem[seg+1]) - longint'(key_mem[seg]);
    f = 0;
    if (den != 0 && num != 0 && ((num > 0) == (den > 0))) begin
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      q = (an << FRACTION_BITS) / ad;
      if (q > one) q = one;
      f = q;
    end
    if (seg > 1 && seg < n - 2) begin
      ym = val_mem[seg-1]; y0 = val_mem[seg];
      y1 = val_mem[seg+1]; y2 = val_mem[seg+2];
      a0 = y2 - y1 - ym + y0;
      a1 = ym - y0 - a0;
      a2 = y1 - ym;
      res = round_frac(a0 * f) + a1;
      res = round_frac(res * f) + a2;
      res = round_frac(res * f) + y0;
    end else begin
      res = round_frac(f * longint'(val_mem[seg+1]) + (one - f) * longint'(val_mem[seg]));
    end
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
      r.saturated = 1'b1;
    end
    if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
      r.saturated = 1'b1;
    end
    r.interp_value = res[31:0];
    return r;
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES && !timed_out) begin
      timed_out <= 1'b1;
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, compare each transaction with the oldest expectation
  int stall_left = 0;
  bit calm_sink = 1'b0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result value=%0d sat=%0b", out_item.interp_value,
                     out_item.saturated);
        end else begin
          out_item_t e;
          e = expected_q.pop_front();
          if (out_item.interp_value !== e.interp_value || out_item.saturated !== e.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value=%0d sat=%0b, actual value=%0d sat=%0b",
                       e.interp_value, e.saturated, out_item.interp_value, out_item.saturated);
          end
        end
        stall_left = calm_sink ? 0 : $urandom_range(0, 13);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  bit calm_source = 1'b0;

  // one input transaction; the predictor runs at acceptance
  // valid stays up into a back-to-back transaction and drops before any gap
  task automatic send_item(in_item_t it);
    int gap;
    gap = calm_source ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.cmd == CMD_WRITE) begin
      key_mem[it.entry_index] = it.key_value;
      val_mem[it.entry_index] = it.entry_data;
    end else begin
      expected_q.insert(expected_q.size(), interpolate(it.key_value));
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(int n);
    cfg_valid <= 1'b1;
    cfg_wdata <= CFG_W'(n);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg = CFG_W'(n);
  endtask

  function automatic in_item_t make_write(int idx, logic signed [31:0] k, logic signed [31:0] v);
    in_item_t it;
    it.cmd = CMD_WRITE;
    it.entry_index = idx[9:0];
    it.key_value = k;
    it.entry_data = v;
    return it;
  endfunction

  function automatic in_item_t make_query(logic signed [31:0] k);
    in_item_t it;
    it.cmd = CMD_QUERY;
    it.entry_index = 10'($urandom);
    it.key_value = k;
    it.entry_data = $urandom;
    return it;
  endfunction

  // fill entries [0, n) with ordered keys, random step sizes and values
  task automatic fill_table(int n, bit ascending, bit wide_vals);
    logic signed [31:0] k, v, step;
    int span;
    span = 32'h7000_0000 / n;
    k = ascending ? -32'sh3800_0000 : 32'sh3800_0000;
    for (int e = 0; e < n; e++) begin
      v = wide_vals ? $urandom : $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      send_item(make_write(e, k, v));
      step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, span);
      k = ascending ? k + step : k - step;
    end
    if (n > n_written) n_written = n;
  endtask

  function automatic logic signed [31:0] pick_key(int n);
    int e;
    e = $urandom_range(0, n - 1);
    case ($urandom_range(0, 5))
      0: return key_mem[e];
      1: return $urandom;
      default: return key_mem[e] + $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  // directed stimulus: writes, then queries whose result is obvious
  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  stim_row_t dir_rows[$];
  int sent = 0;

  task automatic add_row(in_item_t it, bit typed, out_item_t res);
    stim_row_t row;
    row.it = it;
    row.typed = typed;
    row.res = res;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  initial begin
    stim_row_t row;
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // entries_in_use stays at its reset value of 2 for the first rows
    add_row(make_write(0, 32'sh0000_0000, 32'sh0000_0000), 1'b0, '0);
    add_row(make_write(1, 32'sh0001_0000, 32'sh0064_0000), 1'b0, '0);
    add_row(make_query(32'sh0000_0000), 1'b1, '{32'sh0000_0000, 1'b0});
    add_row(make_query(32'sh0001_0000), 1'b1, '{32'sh0064_0000, 1'b0});
    add_row(make_query(32'sh0000_8000), 1'b1, '{32'sh0032_0000, 1'b0});
    add_row(make_query(32'sh7fff_ffff), 1'b1, '{32'sh0064_0000, 1'b0});
    add_row(make_query(-32'sh8000_0000), 1'b1, '{32'sh0000_0000, 1'b0});
    // extreme keys and values at the ends
    add_row(make_write(0, -32'sh8000_0000, 32'sh7fff_ffff), 1'b0, '0);
    add_row(make_write(1, 32'sh7fff_ffff, -32'sh8000_0000), 1'b0, '0);
    add_row(make_query(-32'sh8000_0000), 1'b1, '{32'sh7fff_ffff, 1'b0});
    add_row(make_query(32'sh7fff_ffff), 1'b1, '{-32'sh8000_0000, 1'b0});
    add_row(make_query(32'sh0000_0000), 1'b0, '0);
    // zero-width segment gives f of zero
    add_row(make_write(1, -32'sh8000_0000, 32'sh0000_1234), 1'b0, '0);
    add_row(make_query(-32'sh8000_0000), 1'b1, '{32'sh7fff_ffff, 1'b0});
    // descending table
    add_row(make_write(0, 32'sh0010_0000, 32'sh0001_0000), 1'b0, '0);
    add_row(make_write(1, -32'sh0010_0000, 32'sh0003_0000), 1'b0, '0);
    add_row(make_query(32'sh0000_0000), 1'b1, '{32'sh0002_0000, 1'b0});
    add_row(make_query(32'sh0020_0000), 1'b1, '{32'sh0001_0000, 1'b0});
    add_row(make_query(-32'sh0020_0000), 1'b1, '{32'sh0003_0000, 1'b0});
    // writes at the top position and in the middle of the table
    add_row(make_write(1023, 32'sh1234_5678, -32'sh1234_5678), 1'b0, '0);
    add_row(make_write(512, -32'sh1, 32'sh1), 1'b0, '0);

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      send_item(row.it);
      sent++;
      if (row.typed && expected_q.size() != 0) begin
        if (expected_q[$] !== row.res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("predictor disagrees on directed row %0d: typed %0d, predicted %0d",
                     r, row.res.interp_value, expected_q[$].interp_value);
        end
      end
    end
    n_written = 2;

    // random phases over several entry counts, extremes included
    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      case (ph)
        0: n = 2;
        1: n = 3;
        2: n = 1024;
        3: n = 4;
        4: n = 5;
        default: n = $urandom_range(2, 24);
      endcase
      // counts below 2 act as 2 but only if entries 0,1 exist, which they do
      if (ph == 6) n = 0;
      if (ph == 7) n = 1;
      if (ph == 8) n = 2047;
      write_count(n);
      n = clamp_count();
      if (n > n_written || $urandom_range(0, 1)) begin
        fill_table(n, $urandom_range(0, 1), ph % 3 == 2);
        sent += n;
      end
      if (ph == 4) begin
        calm_source = 1'b1;
        calm_sink = 1'b1;
      end else begin
        calm_source = 1'b0;
        calm_sink = 1'b0;
      end
      for (int q = 0; q < 65; q++) begin
        // sender holds back until the output side has caught up
        if (ph == 3 && q == 32) wait_idle();
        if ($urandom_range(0, 15) == 0) begin
          int e;
          e = $urandom_range(0, n_written - 1);
          send_item(make_write(e, pick_key(n), $urandom));
        end else begin
          send_item(make_query(pick_key(n)));
        end
        sent++;
      end
    end

    wait_idle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
